// ===== hw/rtl/bhq_pkg.sv =====
package bhq_pkg;

    localparam int DEPTH_DEF          = 256;
    localparam int PAYLOAD_WIDTH_DEF  = 32;
    localparam int PRIORITY_WIDTH_DEF = 32;

    // fixed beat field widths
    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 32;
    localparam int PAY_W    = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

// ===== hw/rtl/bhq_ifs.sv =====
interface bhq_req_if;
    logic                                 valid;
    logic                                 ready;
    bhq_pkg::cmd_t                        command;
    logic signed [bhq_pkg::PRIO_W-1:0]    priority_req;
    logic        [bhq_pkg::PAY_W-1:0]     payload;
    logic        [bhq_pkg::INDEX_W-1:0]   index;

    modport source (output valid, command, priority_req, payload, index, input ready);
    modport sink   (input valid, command, priority_req, payload, index, output ready);
endinterface

interface bhq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    bhq_pkg::status_t                     status;
    logic signed [bhq_pkg::PRIO_W-1:0]    out_priority;
    logic        [bhq_pkg::PAY_W-1:0]     out_payload;
    logic        [bhq_pkg::COUNT_W-1:0]   count;

    modport source (output valid, status, out_priority, out_payload, count, input ready);
    modport sink   (input valid, status, out_priority, out_payload, count, output ready);
endinterface

// ===== hw/rtl/binary_min_heap_queue.sv =====
// binary min-heap priority queue of (signed priority, payload) entries
// req channel: one beat per command (push, pop minimum, read at index);
// ready is high only while the sequencer is idle, one command at a time
// rsp channel: exactly one beat per command with status, entry and count
// the heap lives in one memory with one write and one registered read port;
// a single signed comparator is shared by all sift steps
// a push places the new entry at the end and lets it climb past larger parents;
// a pop returns the root, moves the last entry to the root and lets it sink past smaller children
// the result sits in an output register: a stalled rsp keeps its beat
// while the next req beat is accepted; a finished command waits for the
// slot to empty before it leaves and the block takes no new command
// reset empties the queue at once (count zero); the memory is not cleared,
// positions at or beyond the count never reach a response
module binary_min_heap_queue #(
    parameter int DEPTH          = bhq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH  = bhq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = bhq_pkg::PRIORITY_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bhq_req_if.sink    req,
    bhq_rsp_if.source  rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = AW + 2;
    localparam int PW   = PRIORITY_WIDTH;
    localparam int DW   = PAYLOAD_WIDTH;
    localparam int EW   = PW + DW;
    localparam int CMPW = (CW > bhq_pkg::INDEX_W) ? CW : bhq_pkg::INDEX_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LAST,
        S_POP_LOAD,
        S_DN_L,
        S_DN_R,
        S_DN_RC,
        S_DN_SW,
        S_READ,
        S_DONE
    } state_t;

    // heap storage
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_wdata;

    state_t                   state_reg,      state_next;
    logic [CW-1:0]            cnt_reg,        cnt_next;
    logic [AW-1:0]            pos_reg,        pos_next;
    logic [EW-1:0]            cur_reg,        cur_next;
    logic [EW-1:0]            best_reg,       best_next;
    logic [AW-1:0]            best_idx_reg,   best_idx_next;
    logic                     best_hit_reg,   best_hit_next;
    bhq_pkg::status_t         res_status_reg, res_status_next;
    logic signed [PW-1:0]     res_prio_reg,   res_prio_next;
    logic [DW-1:0]            res_pay_reg,    res_pay_next;
    logic                     rsp_valid_reg,  rsp_valid_next;
    bhq_pkg::status_t         rsp_status_reg, rsp_status_next;
    logic signed [bhq_pkg::PRIO_W-1:0]  rsp_prio_reg,  rsp_prio_next;
    logic [bhq_pkg::PAY_W-1:0]          rsp_pay_reg,   rsp_pay_next;
    logic [bhq_pkg::COUNT_W-1:0]        rsp_count_reg, rsp_count_next;

    logic signed [PW-1:0] rd_prio;
    logic signed [PW-1:0] cur_prio;
    logic signed [PW-1:0] best_prio;
    logic signed [PW-1:0] cmp_a;
    logic signed [PW-1:0] cmp_b;
    logic                 cmp_lt;
    logic [IW-1:0]        left_idx;
    logic [IW-1:0]        right_idx;
    logic                 left_ok;
    logic                 right_ok;
    logic [AW-1:0]        parent_idx;

    assign rd_prio   = rdata_reg[EW-1:DW];
    assign cur_prio  = cur_reg[EW-1:DW];
    assign best_prio = best_reg[EW-1:DW];

    assign left_idx   = (IW'(pos_reg) << 1) + IW'(1);
    assign right_idx  = left_idx + IW'(1);
    assign left_ok    = left_idx < IW'(cnt_reg);
    assign right_ok   = right_idx < IW'(cnt_reg);
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);

    // shared comparator, operands picked by the sequencer step
    always_comb
    begin
        unique case (state_reg)
            S_DN_R:
            begin
                cmp_a = rd_prio;
                cmp_b = cur_prio;
            end
            S_DN_RC:
            begin
                cmp_a = rd_prio;
                cmp_b = best_prio;
            end
            default:
            begin
                cmp_a = cur_prio;
                cmp_b = rd_prio;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_hit_next   = best_hit_reg;
        res_status_next = res_status_reg;
        res_prio_next   = res_prio_reg;
        res_pay_next    = res_pay_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_prio_next   = rsp_prio_reg;
        rsp_pay_next    = rsp_pay_reg;
        rsp_count_next  = rsp_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = cur_reg;
        mem_raddr       = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.command == bhq_pkg::CMD_READ)
                begin
                    mem_raddr = AW'(req.index);
                end
                if (req.valid)
                begin
                    res_status_next = bhq_pkg::ST_OK;
                    res_prio_next   = '0;
                    res_pay_next    = '0;
                    state_next      = S_DONE;
                    case (req.command)
                        bhq_pkg::CMD_PUSH:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                res_status_next = bhq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cur_next   = {PW'(req.priority_req), DW'(req.payload)};
                                pos_next   = AW'(cnt_reg);
                                cnt_next   = cnt_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        bhq_pkg::CMD_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = bhq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // root read issued this cycle
                                state_next = S_POP_LAST;
                            end
                        end
                        bhq_pkg::CMD_READ:
                        begin
                            if (CMPW'(req.index) >= CMPW'(cnt_reg))
                            begin
                                res_status_next = bhq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    // parent moves down into the hole
                    mem_wdata  = rdata_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_POP_LAST:
            begin
                res_prio_next = rd_prio;
                res_pay_next  = rdata_reg[DW-1:0];
                mem_raddr     = AW'(cnt_reg - CW'(1));
                cnt_next      = cnt_reg - CW'(1);
                state_next    = S_POP_LOAD;
            end

            S_POP_LOAD:
            begin
                cur_next = rdata_reg;
                pos_next = '0;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end

            S_DN_L:
            begin
                if (!left_ok)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = AW'(left_idx);
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                best_hit_next = cmp_lt;
                best_next     = cmp_lt ? rdata_reg : cur_reg;
                best_idx_next = AW'(left_idx);
                if (right_ok)
                begin
                    mem_raddr  = AW'(right_idx);
                    state_next = S_DN_RC;
                end
                else
                begin
                    state_next = S_DN_SW;
                end
            end

            S_DN_RC:
            begin
                if (cmp_lt)
                begin
                    best_next     = rdata_reg;
                    best_idx_next = AW'(right_idx);
                    best_hit_next = 1'b1;
                end
                state_next = S_DN_SW;
            end

            S_DN_SW:
            begin
                mem_we = 1'b1;
                if (best_hit_reg)
                begin
                    // smaller child moves up into the hole
                    mem_wdata  = best_reg;
                    pos_next   = best_idx_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                res_prio_next = rd_prio;
                res_pay_next  = rdata_reg[DW-1:0];
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_prio_next   = bhq_pkg::PRIO_W'(res_prio_reg);
                    rsp_pay_next    = bhq_pkg::PAY_W'(res_pay_reg);
                    rsp_count_next  = bhq_pkg::COUNT_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        best_hit_reg   <= best_hit_next;
        res_status_reg <= res_status_next;
        res_prio_reg   <= res_prio_next;
        res_pay_reg    <= res_pay_next;
        rsp_status_reg <= rsp_status_next;
        rsp_prio_reg   <= rsp_prio_next;
        rsp_pay_reg    <= rsp_pay_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.out_priority = rsp_prio_reg;
    assign rsp.out_payload  = rsp_pay_reg;
    assign rsp.count        = rsp_count_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == bhq_pkg::ST_FULL
            |-> rsp.count == bhq_pkg::COUNT_W'(DEPTH))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == bhq_pkg::ST_EMPTY |-> rsp.count == '0)
        else $error("empty status with entries held");

    a_sift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_RD || state_reg == S_UP_CMP || state_reg == S_DN_L
            || state_reg == S_DN_R || state_reg == S_DN_RC || state_reg == S_DN_SW)
            |-> CW'(pos_reg) < cnt_reg)
        else $error("sift position outside the heap");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.command == bhq_pkg::CMD_PUSH
            && cnt_reg != CW'(DEPTH)
            |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("push did not grow the count");

endmodule

// ===== tb/binary_min_heap_queue_tb.sv =====
module binary_min_heap_queue_tb;

    localparam int HEAP_SIZE  = bhq_pkg::DEPTH_DEF;
    localparam int HALF_CLK   = 4;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        bhq_pkg::status_t                   status;
        logic signed [bhq_pkg::PRIO_W-1:0]  prio;
        logic        [bhq_pkg::PAY_W-1:0]   pay;
        logic        [bhq_pkg::COUNT_W-1:0] count;
    } heap_result_t;

    logic clk;
    logic rst_n;

    bhq_req_if req_bus ();
    bhq_rsp_if rsp_bus ();

    binary_min_heap_queue uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // mirror of the heap contents
    logic signed [bhq_pkg::PRIO_W-1:0] heap_prios [HEAP_SIZE];
    logic        [bhq_pkg::PAY_W-1:0]  heap_pays  [HEAP_SIZE];
    int                                held;

    heap_result_t pending_results[$];
    int           errors;
    bit           no_gaps;

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_CLK clk = ~clk;

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic void swap_entries(int a, int b);
        logic signed [bhq_pkg::PRIO_W-1:0] tp;
        logic        [bhq_pkg::PAY_W-1:0]  td;
        tp = heap_prios[a];
        td = heap_pays[a];
        heap_prios[a] = heap_prios[b];
        heap_pays[a]  = heap_pays[b];
        heap_prios[b] = tp;
        heap_pays[b]  = td;
    endfunction

    function automatic heap_result_t heap_apply(bhq_pkg::cmd_t c,
                                                logic signed [bhq_pkg::PRIO_W-1:0] p,
                                                logic [bhq_pkg::PAY_W-1:0] d,
                                                logic [bhq_pkg::INDEX_W-1:0] idx);
        heap_result_t r;
        int pos;
        int parent;
        int best;
        int lft;
        int rgt;
        r.status = bhq_pkg::ST_OK;
        r.prio   = '0;
        r.pay    = '0;
        case (c)
            bhq_pkg::CMD_PUSH:
            begin
                if (held >= HEAP_SIZE)
                    r.status = bhq_pkg::ST_FULL;
                else
                begin
                    pos = held;
                    heap_prios[pos] = p;
                    heap_pays[pos]  = d;
                    held++;
                    while (pos > 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (heap_prios[pos] < heap_prios[parent])
                        begin
                            swap_entries(pos, parent);
                            pos = parent;
                        end
                        else
                            break;
                    end
                end
            end
            bhq_pkg::CMD_POP:
            begin
                if (held == 0)
                    r.status = bhq_pkg::ST_EMPTY;
                else
                begin
                    r.prio = heap_prios[0];
                    r.pay  = heap_pays[0];
                    held--;
                    heap_prios[0] = heap_prios[held];
                    heap_pays[0]  = heap_pays[held];
                    pos = 0;
                    forever
                    begin
                        best = pos;
                        lft  = 2 * pos + 1;
                        rgt  = 2 * pos + 2;
                        if (lft < held && heap_prios[lft] < heap_prios[best])
                            best = lft;
                        if (rgt < held && heap_prios[rgt] < heap_prios[best])
                            best = rgt;
                        if (best == pos)
                            break;
                        swap_entries(pos, best);
                        pos = best;
                    end
                end
            end
            bhq_pkg::CMD_READ:
            begin
                if (int'(idx) >= held)
                    r.status = bhq_pkg::ST_RANGE;
                else
                begin
                    r.prio = heap_prios[idx];
                    r.pay  = heap_pays[idx];
                end
            end
            default:
            begin
            end
        endcase
        r.count = bhq_pkg::COUNT_W'(held);
        return r;
    endfunction

    // one request beat; valid stays high when the next beat follows with no gap
    task automatic send_cmd(bhq_pkg::cmd_t c, logic signed [bhq_pkg::PRIO_W-1:0] p,
                            logic [bhq_pkg::PAY_W-1:0] d,
                            logic [bhq_pkg::INDEX_W-1:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.command      <= c;
        req_bus.priority_req <= p;
        req_bus.payload      <= d;
        req_bus.index        <= idx;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        pending_results.push_back(heap_apply(c, p, d, idx));
    endtask

    function automatic logic signed [bhq_pkg::PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 7) - 4;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return {4'($urandom_range(0, 15)), 28'h0};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bhq_pkg::INDEX_W-1:0] rand_index();
        if (held > 0 && $urandom_range(0, 3) != 0)
            return bhq_pkg::INDEX_W'($urandom_range(0, held - 1));
        return bhq_pkg::INDEX_W'($urandom_range(0, 255));
    endfunction

    task automatic push_rand();
        send_cmd(bhq_pkg::CMD_PUSH, rand_prio(), $urandom, bhq_pkg::INDEX_W'($urandom));
    endtask

    task automatic pop_one();
        send_cmd(bhq_pkg::CMD_POP, $urandom, $urandom, bhq_pkg::INDEX_W'($urandom));
    endtask

    task automatic read_rand();
        send_cmd(bhq_pkg::CMD_READ, $urandom, $urandom, rand_index());
    endtask

    task automatic test_directed();
        send_cmd(bhq_pkg::CMD_POP, 32'sd0, 32'h0, 8'd0);
        send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, 8'd0);
        send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, 8'hff);
        send_cmd(bhq_pkg::CMD_NOP, 32'sh7fffffff, 32'hffffffff, 8'hff);
        send_cmd(bhq_pkg::CMD_PUSH, 32'sh7fffffff, 32'hffffffff, 8'hff);
        send_cmd(bhq_pkg::CMD_PUSH, 32'sh80000000, 32'h0, 8'h0);
        send_cmd(bhq_pkg::CMD_PUSH, 32'sd0, 32'h5a5a5a5a, 8'h55);
        // equal priority: an entry climbs only past a larger parent, never an equal one
        send_cmd(bhq_pkg::CMD_PUSH, 32'sd0, 32'ha5a5a5a5, 8'haa);
        send_cmd(bhq_pkg::CMD_PUSH, -32'sd1, 32'h12345678, 8'h0);
        for (int i = 0; i < 5; i++)
            send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, bhq_pkg::INDEX_W'(i));
        send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, 8'd5);
        send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, 8'hff);
        send_cmd(bhq_pkg::CMD_NOP, 32'sh80000000, 32'h0, 8'h0);
        for (int i = 0; i < 5; i++)
            pop_one();
        send_cmd(bhq_pkg::CMD_POP, 32'sh7fffffff, 32'hffffffff, 8'hff);
    endtask

    task automatic test_fill_and_drain();
        no_gaps = 1'b1;
        while (held < HEAP_SIZE)
        begin
            if (held == HEAP_SIZE / 2)
                no_gaps = 1'b0;
            if ($urandom_range(0, 9) == 0)
                read_rand();
            else
                push_rand();
        end
        for (int i = 0; i < 3; i++)
            push_rand();
        send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, 8'hff);
        send_cmd(bhq_pkg::CMD_READ, 32'sd0, 32'h0, 8'h00);
        for (int i = 0; i < 8; i++)
            send_cmd(bhq_pkg::CMD_READ, $urandom, $urandom,
                     bhq_pkg::INDEX_W'($urandom_range(0, 255)));
        while (held > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                read_rand();
            else
                pop_one();
        end
        pop_one();
    endtask

    task automatic test_random_mix();
        int push_bias;
        int r;
        for (int seg = 0; seg < 7; seg++)
        begin
            // alternate growing and shrinking stretches so the depth wanders
            push_bias = (seg % 2 == 0) ? 65 : 25;
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 100; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < push_bias)
                    push_rand();
                else if (r < push_bias + 15)
                    read_rand();
                else if (r < push_bias + 20)
                    send_cmd(bhq_pkg::CMD_NOP, rand_prio(), $urandom,
                             bhq_pkg::INDEX_W'($urandom));
                else
                    pop_one();
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic check_result();
        heap_result_t e;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result beat with nothing outstanding");
            return;
        end
        e = pending_results.pop_front();
        if (rsp_bus.status !== e.status)
            report_mismatch($sformatf("status %0d, wanted %0d", rsp_bus.status, e.status));
        if (rsp_bus.out_priority !== e.prio)
            report_mismatch($sformatf("priority %0d, wanted %0d", rsp_bus.out_priority, e.prio));
        if (rsp_bus.out_payload !== e.pay)
            report_mismatch($sformatf("payload %h, wanted %h", rsp_bus.out_payload, e.pay));
        if (rsp_bus.count !== e.count)
            report_mismatch($sformatf("count %0d, wanted %0d", rsp_bus.count, e.count));
    endtask

    // result side: random stall before each beat (none while no_gaps is set), then check it
    initial
    begin
        int stall;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
            check_result();
        end
    end

    initial
    begin
        errors  = 0;
        held    = 0;
        no_gaps = 1'b0;
        rst_n                <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.command      <= bhq_pkg::CMD_NOP;
        req_bus.priority_req <= '0;
        req_bus.payload      <= '0;
        req_bus.index        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix();

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
